>>> rtl/trimmed_mean_irrigation_decider_defines.svh
// assertion macros for the trimmed mean irrigation decider checker
// expects clk and arst_n in the scope where a macro is used
`ifndef TRIMMED_MEAN_IRRIGATION_DECIDER_DEFINES_SVH
`define TRIMMED_MEAN_IRRIGATION_DECIDER_DEFINES_SVH

// same-cycle implication
`define TMID_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TMID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tmid_pkg.sv
// shared types, widths and codes for the trimmed mean irrigation decider
// no dependencies
package tmid_pkg;

	localparam int MAX_SAMPLES = 256;

	localparam int TEMP_W = 12;
	localparam int HUM_W  = 10;
	localparam int SAL_W  = 11;
	localparam int STAT_W = 2;

	localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
	localparam int LOG_MAX = $clog2(MAX_SAMPLES);
	localparam int TSUM_W  = TEMP_W + LOG_MAX;
	localparam int HSUM_W  = HUM_W + LOG_MAX;
	localparam int SSUM_W  = SAL_W + LOG_MAX;
	localparam int DVSR_W  = LOG_MAX;
	localparam int DVND_W  = TSUM_W;
	localparam int ITER_W  = $clog2(DVND_W + 1);
	localparam int PROD_W  = TEMP_W + 1 + DVSR_W + 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = TEMP_W;

	localparam logic [CFG_IDX_W-1:0] REG_HUM_DRY  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_HOT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_HOT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SAL_HIGH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_SAL  = 3'd4;

	localparam logic [HUM_W-1:0]  RST_HUM_DRY  = 10'd400;
	localparam logic [TEMP_W-1:0] RST_TEMP_HOT = 12'd300;
	localparam logic [HUM_W-1:0]  RST_HUM_HOT  = 10'd600;
	localparam logic [SAL_W-1:0]  RST_SAL_HIGH = 11'd250;
	localparam logic [HUM_W-1:0]  RST_HUM_SAL  = 10'd500;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FEW  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_DROP = 2'd2;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature;
		logic [HUM_W-1:0]         humidity;
		logic [SAL_W-1:0]         salinity;
		logic                     last;
	} sample_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] mean_temperature;
		logic [HUM_W-1:0]         mean_humidity;
		logic [SAL_W-1:0]         mean_salinity;
		logic                     irrigate;
		logic [STAT_W-1:0]        status;
	} result_t;

	typedef struct packed {
		logic [HUM_W-1:0]         hum_dry;
		logic signed [TEMP_W-1:0] temp_hot;
		logic [HUM_W-1:0]         hum_hot;
		logic [SAL_W-1:0]         sal_high;
		logic [HUM_W-1:0]         hum_sal;
	} cfg_t;

	typedef struct packed {
		logic signed [TSUM_W-1:0] tsum;
		logic [HSUM_W-1:0]        hsum;
		logic [SSUM_W-1:0]        ssum;
		logic signed [TEMP_W-1:0] tmin;
		logic signed [TEMP_W-1:0] tmax;
		logic [HUM_W-1:0]         hmin;
		logic [HUM_W-1:0]         hmax;
		logic [SAL_W-1:0]         smin;
		logic [SAL_W-1:0]         smax;
		logic [CNT_W-1:0]         count;
		logic                     ovf;
	} acc_t;

	typedef struct packed {
		logic done;
		logic irrigate;
	} dec_t;

endpackage

>>> rtl/trimmed_mean_irrigation_decider.sv
// trimmed mean irrigation decider, top level: config registers and sequencer
// a non-last word is taken while busy stays low, one word per cycle; on a last word
// S_LOAD snapshots the trimmed sums, the serial divider works the three channels in turn
// in S_DIV and S_OUT raises done once the decision is ready; too few samples skip S_DIV
// done is high for one cycle, cannot be held off; reset clears batch, sets default limits
// depends on tmid_pkg, tmid_acc, tmid_div, tmid_dec
module trimmed_mean_irrigation_decider import tmid_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  sample_t               sample,
	output logic                  done,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOAD = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	localparam logic [1:0] CH_TEMP = 2'd0;
	localparam logic [1:0] CH_HUM  = 2'd1;
	localparam logic [1:0] CH_SAL  = 2'd2;

	logic [1:0]               state_q;
	logic [1:0]               chan_q;
	cfg_t                     cfg_q;
	acc_t                     acc;
	dec_t                     dec;
	logic                     accept;
	logic signed [TSUM_W-1:0] ts_c, ts_q;
	logic [HSUM_W-1:0]        hs_c, hs_q;
	logic [SSUM_W-1:0]        ss_c, ss_q;
	logic [CNT_W-1:0]         d_c;
	logic                     few_c;
	logic [DVSR_W-1:0]        dvsr_q;
	logic                     few_q, ovf_q;
	logic                     div_go_q, dec_go_q;
	logic                     div_done;
	logic [DVND_W-1:0]        div_quot;
	logic [DVND_W-1:0]        dividend;
	logic                     ts_neg;
	logic [TEMP_W-1:0]        qt_q;
	logic [HUM_W-1:0]         qh_q;
	logic [SAL_W-1:0]         qs_q;
	logic                     done_q;
	result_t                  result_q;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = result_q;

	// trimmed sums
	assign ts_c  = acc.tsum - {{LOG_MAX{acc.tmin[TEMP_W-1]}}, acc.tmin}
		- {{LOG_MAX{acc.tmax[TEMP_W-1]}}, acc.tmax};
	assign hs_c  = acc.hsum - {{LOG_MAX{1'b0}}, acc.hmin} - {{LOG_MAX{1'b0}}, acc.hmax};
	assign ss_c  = acc.ssum - {{LOG_MAX{1'b0}}, acc.smin} - {{LOG_MAX{1'b0}}, acc.smax};
	assign d_c   = acc.count - CNT_W'(2);
	assign few_c = acc.count < CNT_W'(3);

	assign ts_neg = ts_q[TSUM_W-1];

	always_comb begin
		case (chan_q)
			CH_TEMP: dividend = ts_neg ? DVND_W'(-ts_q) : DVND_W'(ts_q);
			CH_HUM:  dividend = {{(DVND_W-HSUM_W){1'b0}}, hs_q};
			CH_SAL:  dividend = {{(DVND_W-SSUM_W){1'b0}}, ss_q};
			default: dividend = '0;
		endcase
	end

	tmid_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (accept),
		.clear  (state_q == S_LOAD),
		.sample (sample),
		.acc    (acc)
	);

	tmid_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (dividend),
		.divisor  (dvsr_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	tmid_dec u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dec_go_q),
		.cfg    (cfg_q),
		.tsum   (ts_q),
		.hsum   (hs_q),
		.ssum   (ss_q),
		.dvsr   (dvsr_q),
		.dec    (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hum_dry  <= RST_HUM_DRY;
			cfg_q.temp_hot <= RST_TEMP_HOT;
			cfg_q.hum_hot  <= RST_HUM_HOT;
			cfg_q.sal_high <= RST_SAL_HIGH;
			cfg_q.hum_sal  <= RST_HUM_SAL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HUM_DRY:  cfg_q.hum_dry  <= cfg_data[HUM_W-1:0];
				REG_TEMP_HOT: cfg_q.temp_hot <= cfg_data[TEMP_W-1:0];
				REG_HUM_HOT:  cfg_q.hum_hot  <= cfg_data[HUM_W-1:0];
				REG_SAL_HIGH: cfg_q.sal_high <= cfg_data[SAL_W-1:0];
				REG_HUM_SAL:  cfg_q.hum_sal  <= cfg_data[HUM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			chan_q   <= CH_TEMP;
			div_go_q <= 1'b0;
			dec_go_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			div_go_q <= 1'b0;
			dec_go_q <= 1'b0;
			done_q   <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && sample.last) state_q <= S_LOAD;
				end
				S_LOAD: begin
					chan_q   <= CH_TEMP;
					div_go_q <= !few_c;
					dec_go_q <= !few_c;
					state_q  <= few_c ? S_OUT : S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						if (chan_q == CH_SAL) begin
							state_q <= S_OUT;
						end else begin
							chan_q   <= chan_q + 1'b1;
							div_go_q <= 1'b1;
						end
					end
				end
				S_OUT: begin
					if (few_q || dec.done) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// batch snapshot, quotients and result word
	always_ff @(posedge clk) begin
		if (state_q == S_LOAD) begin
			ts_q   <= ts_c;
			hs_q   <= hs_c;
			ss_q   <= ss_c;
			dvsr_q <= d_c[DVSR_W-1:0];
			few_q  <= few_c;
			ovf_q  <= acc.ovf;
		end
		if (state_q == S_DIV && div_done) begin
			case (chan_q)
				CH_TEMP: qt_q <= div_quot[TEMP_W-1:0];
				CH_HUM:  qh_q <= div_quot[HUM_W-1:0];
				CH_SAL:  qs_q <= div_quot[SAL_W-1:0];
				default: ;
			endcase
		end
		if (state_q == S_OUT) begin
			if (few_q) begin
				result_q.mean_temperature <= '0;
				result_q.mean_humidity    <= '0;
				result_q.mean_salinity    <= '0;
				result_q.irrigate         <= 1'b0;
				result_q.status           <= STAT_FEW;
			end else begin
				result_q.mean_temperature <= ts_neg ? -qt_q : qt_q;
				result_q.mean_humidity    <= qh_q;
				result_q.mean_salinity    <= qs_q;
				result_q.irrigate         <= dec.irrigate;
				result_q.status           <= ovf_q ? STAT_DROP : STAT_OK;
			end
		end
	end

endmodule

>>> rtl/tmid_acc.sv
// batch accumulator: per-channel sums, minimum, maximum, sample count
// depends on tmid_pkg
module tmid_acc import tmid_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    take,
	input  logic    clear,
	input  sample_t sample,
	output acc_t    acc
);

	acc_t acc_q;
	logic room;

	assign room = acc_q.count < CNT_W'(MAX_SAMPLES);
	assign acc  = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (clear) begin
			acc_q <= '0;
		end else if (take) begin
			if (!room) begin
				acc_q.ovf <= 1'b1;
			end else begin
				acc_q.count <= acc_q.count + 1'b1;
				acc_q.tsum  <= acc_q.tsum +
					{{LOG_MAX{sample.temperature[TEMP_W-1]}}, sample.temperature};
				acc_q.hsum  <= acc_q.hsum + {{LOG_MAX{1'b0}}, sample.humidity};
				acc_q.ssum  <= acc_q.ssum + {{LOG_MAX{1'b0}}, sample.salinity};
				if (acc_q.count == '0) begin
					acc_q.tmin <= sample.temperature;
					acc_q.tmax <= sample.temperature;
					acc_q.hmin <= sample.humidity;
					acc_q.hmax <= sample.humidity;
					acc_q.smin <= sample.salinity;
					acc_q.smax <= sample.salinity;
				end else begin
					if (sample.temperature < acc_q.tmin) acc_q.tmin <= sample.temperature;
					if (sample.temperature > acc_q.tmax) acc_q.tmax <= sample.temperature;
					if (sample.humidity < acc_q.hmin) acc_q.hmin <= sample.humidity;
					if (sample.humidity > acc_q.hmax) acc_q.hmax <= sample.humidity;
					if (sample.salinity < acc_q.smin) acc_q.smin <= sample.salinity;
					if (sample.salinity > acc_q.smax) acc_q.smax <= sample.salinity;
				end
			end
		end
	end

endmodule

>>> rtl/tmid_div.sv
// serial restoring divider, one quotient bit per cycle, unsigned
// depends on tmid_pkg
module tmid_div import tmid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DVND_W-1:0] dividend,
	input  logic [DVSR_W-1:0] divisor,
	output logic              done,
	output logic [DVND_W-1:0] quotient
);

	logic [DVND_W-1:0] dq_q;
	logic [DVSR_W-1:0] rem_q;
	logic [DVSR_W-1:0] dvsr_q;
	logic [ITER_W-1:0] iter_q;
	logic              run_q;
	logic              done_q;
	logic [DVSR_W:0]   trial;
	logic [DVSR_W:0]   diff;
	logic              fits;

	assign trial    = {rem_q, dq_q[DVND_W-1]};
	assign diff     = trial - {1'b0, dvsr_q};
	assign fits     = trial >= {1'b0, dvsr_q};
	assign done     = done_q;
	assign quotient = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dq_q   <= '0;
			rem_q  <= '0;
			dvsr_q <= '0;
			iter_q <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dq_q   <= dividend;
				rem_q  <= '0;
				dvsr_q <= divisor;
				iter_q <= ITER_W'(DVND_W);
				run_q  <= 1'b1;
			end else if (run_q) begin
				dq_q   <= {dq_q[DVND_W-2:0], fits};
				rem_q  <= fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
				iter_q <= iter_q - 1'b1;
				if (iter_q == ITER_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/tmid_dec.sv
// irrigation decision: limit times divisor on one shared multiplier, then compare
// depends on tmid_pkg
module tmid_dec import tmid_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  cfg_t                     cfg,
	input  logic signed [TSUM_W-1:0] tsum,
	input  logic [HSUM_W-1:0]        hsum,
	input  logic [SSUM_W-1:0]        ssum,
	input  logic [DVSR_W-1:0]        dvsr,
	output dec_t                     dec
);

	localparam logic [2:0] STEP_HDRY  = 3'd0;
	localparam logic [2:0] STEP_THOT  = 3'd1;
	localparam logic [2:0] STEP_HHOT  = 3'd2;
	localparam logic [2:0] STEP_SHIGH = 3'd3;
	localparam logic [2:0] STEP_HSAL  = 3'd4;

	logic                     run_q;
	logic [2:0]               step_q;
	logic                     pval_q;
	logic [2:0]               pstep_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     dry_q, hot_t_q, hot_h_q, sal_s_q, sal_h_q, done_q;
	logic signed [TEMP_W:0]   op_a;
	logic signed [DVSR_W:0]   op_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] ts_x, hs_x, ss_x;

	assign op_b = {1'b0, dvsr};
	assign prod = op_a * op_b;
	assign ts_x = {{(PROD_W-TSUM_W){tsum[TSUM_W-1]}}, tsum};
	assign hs_x = {{(PROD_W-HSUM_W){1'b0}}, hsum};
	assign ss_x = {{(PROD_W-SSUM_W){1'b0}}, ssum};

	assign dec.done     = done_q;
	assign dec.irrigate = dry_q | (hot_t_q & hot_h_q) | (sal_s_q & sal_h_q);

	always_comb begin
		unique case (step_q)
			STEP_HDRY:  op_a = {{(TEMP_W+1-HUM_W){1'b0}}, cfg.hum_dry};
			STEP_THOT:  op_a = {cfg.temp_hot[TEMP_W-1], cfg.temp_hot};
			STEP_HHOT:  op_a = {{(TEMP_W+1-HUM_W){1'b0}}, cfg.hum_hot};
			STEP_SHIGH: op_a = {{(TEMP_W+1-SAL_W){1'b0}}, cfg.sal_high};
			STEP_HSAL:  op_a = {{(TEMP_W+1-HUM_W){1'b0}}, cfg.hum_sal};
			default:    op_a = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			step_q  <= STEP_HDRY;
			pval_q  <= 1'b0;
			pstep_q <= STEP_HDRY;
			prod_q  <= '0;
			dry_q   <= 1'b0;
			hot_t_q <= 1'b0;
			hot_h_q <= 1'b0;
			sal_s_q <= 1'b0;
			sal_h_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			pval_q  <= run_q;
			pstep_q <= step_q;
			prod_q  <= prod;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STEP_HDRY;
				done_q <= 1'b0;
			end else if (run_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_HSAL) run_q <= 1'b0;
			end
			if (pval_q) begin
				unique case (pstep_q)
					STEP_HDRY:  dry_q   <= hs_x < prod_q;
					STEP_THOT:  hot_t_q <= ts_x > prod_q;
					STEP_HHOT:  hot_h_q <= hs_x < prod_q;
					STEP_SHIGH: sal_s_q <= ss_x > prod_q;
					STEP_HSAL: begin
						sal_h_q <= hs_x < prod_q;
						done_q  <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

endmodule

>>> rtl/tmid_chk.sv
// port-level checker for the trimmed mean irrigation decider, bound to the top level
// depends on tmid_pkg and trimmed_mean_irrigation_decider_defines.svh
`include "trimmed_mean_irrigation_decider_defines.svh"

module tmid_chk import tmid_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input sample_t sample,
	input logic    done,
	input result_t result
);

	// result word only right after a busy stretch ends
	`TMID_ASSERT_SAME(a_done_ends_busy, done, $past(busy) && !busy, "done outside end of batch")
	`TMID_ASSERT_NEXT(a_done_single, done, !done, "done held over two cycles")
	`TMID_ASSERT_NEXT(a_last_busy, start && !busy && sample.last, busy, "last word did not start work")
	`TMID_ASSERT_NEXT(a_plain_idle, start && !busy && !sample.last, !busy && !done, "plain word made block busy")
	`TMID_ASSERT_SAME(a_few_zero, done && result.status == STAT_FEW, !result.irrigate && result.mean_temperature == '0 && result.mean_humidity == '0 && result.mean_salinity == '0, "short batch gave nonzero result")

endmodule

bind trimmed_mean_irrigation_decider tmid_chk u_tmid_chk (.*);

>>> verif/tmid_checker.sv
// checker for the trimmed mean irrigation decider: watches the sample, result and
// limit ports, predicts every result word and compares it field by field
// depends on tmid_pkg
`timescale 1ns / 1ps
module tmid_checker import tmid_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  busy,
	input  sample_t               sample,
	input  logic                  done,
	input  result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    outstanding
);

	cfg_t    limits;
	longint  t_sum, h_sum, s_sum;
	longint  t_lo, t_hi, h_lo, h_hi, s_lo, s_hi;
	int      kept;
	logic    dropped;
	result_t pending_outcomes[$];

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	task automatic flag(input string what, input longint got, input longint want);
		fail_count++;
		$display("%0t: %s: got %0d, want %0d", $time, what, got, want);
	endtask

	function automatic void clear_batch();
		t_sum = 0;
		h_sum = 0;
		s_sum = 0;
		t_lo = 0;
		t_hi = 0;
		h_lo = 0;
		h_hi = 0;
		s_lo = 0;
		s_hi = 0;
		kept = 0;
		dropped = 1'b0;
	endfunction

	function automatic void fold_sample(input sample_t w);
		longint t, h, s;
		t = longint'($signed(w.temperature));
		h = longint'(w.humidity);
		s = longint'(w.salinity);
		if (kept >= MAX_SAMPLES) begin
			dropped = 1'b1;
			return;
		end
		if (kept == 0) begin
			t_lo = t;
			t_hi = t;
			h_lo = h;
			h_hi = h;
			s_lo = s;
			s_hi = s;
		end else begin
			if (t < t_lo) t_lo = t;
			if (t > t_hi) t_hi = t;
			if (h < h_lo) h_lo = h;
			if (h > h_hi) h_hi = h;
			if (s < s_lo) s_lo = s;
			if (s > s_hi) s_hi = s;
		end
		t_sum += t;
		h_sum += h;
		s_sum += s;
		kept++;
	endfunction

	// trimmed means and irrigation decision for the batch held now
	function automatic result_t trimmed_outcome();
		longint  d, ts, hs, ss, q;
		logic    dry, hot, saline;
		result_t r;
		r = '0;
		if (kept < 3) begin
			r.status = STAT_FEW;
			return r;
		end
		d = longint'(kept) - 2;
		ts = t_sum - t_lo - t_hi;
		hs = h_sum - h_lo - h_hi;
		ss = s_sum - s_lo - s_hi;
		dry = hs < longint'(limits.hum_dry) * d;
		hot = ts > longint'($signed(limits.temp_hot)) * d &&
			hs < longint'(limits.hum_hot) * d;
		saline = ss > longint'(limits.sal_high) * d &&
			hs < longint'(limits.hum_sal) * d;
		q = ts / d;
		r.mean_temperature = q[TEMP_W-1:0];
		q = hs / d;
		r.mean_humidity = q[HUM_W-1:0];
		q = ss / d;
		r.mean_salinity = q[SAL_W-1:0];
		r.irrigate = dry || hot || saline;
		r.status = dropped ? STAT_DROP : STAT_OK;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			limits.hum_dry = RST_HUM_DRY;
			limits.temp_hot = RST_TEMP_HOT;
			limits.hum_hot = RST_HUM_HOT;
			limits.sal_high = RST_SAL_HIGH;
			limits.hum_sal = RST_HUM_SAL;
			clear_batch();
			pending_outcomes.delete();
			outstanding = 0;
		end else begin
			if (done) begin
				if (pending_outcomes.size() == 0) begin
					flag("result word with nothing waiting", 1, 0);
				end else begin
					want = pending_outcomes.pop_front();
					if (result.mean_temperature !== want.mean_temperature)
						flag("mean_temperature", longint'($signed(result.mean_temperature)),
							longint'($signed(want.mean_temperature)));
					if (result.mean_humidity !== want.mean_humidity)
						flag("mean_humidity", result.mean_humidity, want.mean_humidity);
					if (result.mean_salinity !== want.mean_salinity)
						flag("mean_salinity", result.mean_salinity, want.mean_salinity);
					if (result.irrigate !== want.irrigate)
						flag("irrigate", result.irrigate, want.irrigate);
					if (result.status !== want.status)
						flag("status", result.status, want.status);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_HUM_DRY:  limits.hum_dry = cfg_data[HUM_W-1:0];
					REG_TEMP_HOT: limits.temp_hot = cfg_data[TEMP_W-1:0];
					REG_HUM_HOT:  limits.hum_hot = cfg_data[HUM_W-1:0];
					REG_SAL_HIGH: limits.sal_high = cfg_data[SAL_W-1:0];
					REG_HUM_SAL:  limits.hum_sal = cfg_data[HUM_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				fold_sample(sample);
				if (sample.last) begin
					pending_outcomes.push_back(trimmed_outcome());
					clear_batch();
				end
			end
			outstanding = pending_outcomes.size();
		end
	end

endmodule

>>> verif/tb_top.sv
// testbench top for the trimmed mean irrigation decider: clock, reset, sample and
// limit stimulus, verdict; prediction and comparison live in tmid_checker
// depends on tmid_pkg, tmid_checker and the block itself
`timescale 1ns / 1ps
module tb_top;
	import tmid_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	sample_t               sample;
	logic                  done;
	result_t               result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    fail_count;
	int                    outstanding;

	int sender_idle_pct;
	// limits as last written, used only to aim samples near the decision edges
	int aim_hum[3];
	int aim_temp;
	int aim_sal;

	trimmed_mean_irrigation_decider dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample(sample),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tmid_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample(sample),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic push_word(input int t, input int h, input int s, input bit fin);
		sample_t w;
		int      gap;
		w.temperature = t[TEMP_W-1:0];
		w.humidity = h[HUM_W-1:0];
		w.salinity = s[SAL_W-1:0];
		w.last = fin;
		if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
			gap = $urandom_range(1, 5);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start <= 1'b1;
		sample <= w;
		do @(posedge clk); while (busy);
	endtask

	task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_DATA_W-1:0];
		case (idx)
			REG_HUM_DRY:  aim_hum[0] = val & 1023;
			REG_TEMP_HOT: aim_temp = ((val & 4095) ^ 2048) - 2048;
			REG_HUM_HOT:  aim_hum[1] = val & 1023;
			REG_SAL_HIGH: aim_sal = val & 2047;
			REG_HUM_SAL:  aim_hum[2] = val & 1023;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// drop start and let the block drain before touching the limits
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		wait (outstanding == 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic apply_limits(input int mode);
		int hd, th, hh, sh, hs, spare;
		case (mode)
			0: begin
				hd = RST_HUM_DRY; th = 300; hh = RST_HUM_HOT;
				sh = RST_SAL_HIGH; hs = RST_HUM_SAL;
			end
			1: begin
				hd = 0; th = -400; hh = 0; sh = 0; hs = 0;
			end
			2: begin
				hd = 1000; th = 1250; hh = 1000; sh = 2000; hs = 1000;
			end
			3: begin
				hd = $urandom_range(0, 1000);
				th = $urandom_range(0, 1650) - 400;
				hh = $urandom_range(0, 1000);
				sh = $urandom_range(0, 2000);
				hs = $urandom_range(0, 1000);
			end
			default: begin
				hd = $urandom_range(0, 4095);
				th = $urandom_range(0, 4095);
				hh = $urandom_range(0, 4095);
				sh = $urandom_range(0, 4095);
				hs = $urandom_range(0, 4095);
			end
		endcase
		write_limit(REG_HUM_DRY, hd);
		write_limit(REG_TEMP_HOT, th);
		write_limit(REG_HUM_HOT, hh);
		write_limit(REG_SAL_HIGH, sh);
		write_limit(REG_HUM_SAL, hs);
		// index past the register list, must be ignored
		spare = int'(REG_HUM_SAL) + $urandom_range(1, 3);
		write_limit(spare[CFG_IDX_W-1:0], $urandom_range(0, 4095));
	endtask

	task automatic send_batch(input int n, input int style);
		int i, t, h, s, hum_aim, spread;
		hum_aim = aim_hum[$urandom_range(0, 2)];
		spread = $urandom_range(0, 3);
		for (i = 0; i < n; i++) begin
			case (style)
				0: begin
					t = $urandom_range(0, 1650) - 400;
					h = $urandom_range(0, 1000);
					s = $urandom_range(0, 2000);
				end
				1: begin
					t = aim_temp + $urandom_range(0, 2 * spread) - spread;
					h = hum_aim + $urandom_range(0, 2 * spread) - spread;
					s = aim_sal + $urandom_range(0, 2 * spread) - spread;
					if (h < 0) h = 0;
					if (s < 0) s = 0;
				end
				2: begin
					t = $urandom_range(0, 4095);
					h = $urandom_range(0, 1023);
					s = $urandom_range(0, 2047);
				end
				default: begin
					t = $urandom_range(0, 200) - 100 + aim_temp;
					h = $urandom_range(0, 200) + hum_aim - 100;
					s = $urandom_range(0, 200) + aim_sal - 100;
					if (h < 0) h = 0;
					if (s < 0) s = 0;
				end
			endcase
			push_word(t, h, s, i == n - 1);
		end
	endtask

	initial begin
		int ph, seg, words, n;
		arst_n = 1'b0;
		start = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = REG_HUM_DRY;
		cfg_data = '0;
		sender_idle_pct = 34;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed words
		apply_limits(0);
		push_word(100, 300, 100, 1'b1);
		push_word(100, 300, 100, 1'b0);
		push_word(-50, 900, 700, 1'b1);
		push_word(-400, 0, 0, 1'b0);
		push_word(1250, 1000, 2000, 1'b0);
		push_word(-400, 1000, 0, 1'b1);
		push_word(-2048, 1023, 2047, 1'b0);
		push_word(2047, 0, 0, 1'b0);
		push_word(-2048, 1023, 2047, 1'b1);
		push_word(-5, 420, 260, 1'b0);
		push_word(-6, 421, 261, 1'b0);
		push_word(-7, 423, 263, 1'b0);
		push_word(-8, 424, 264, 1'b1);
		repeat (2) push_word(300, 400, 250, 1'b0);
		push_word(300, 400, 250, 1'b1);
		repeat (2) push_word(350, 500, 100, 1'b0);
		push_word(350, 500, 100, 1'b1);
		repeat (2) push_word(200, 450, 300, 1'b0);
		push_word(200, 450, 300, 1'b1);

		// random batches, three idling phases, several limit settings each
		for (ph = 0; ph < 3; ph++) begin
			sender_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 55 : 0;
			for (seg = 0; seg < 3; seg++) begin
				settle();
				apply_limits((ph * 3 + seg) % 5);
				if (seg == 1 && ph == 0)
					send_batch($urandom_range(257, 262), $urandom_range(0, 3));
				if (seg == 1 && ph == 2)
					send_batch($urandom_range(255, 256), $urandom_range(0, 3));
				words = 0;
				while (words < 50) begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
					send_batch(n, $urandom_range(0, 3));
					words += n;
				end
			end
		end

		@(negedge clk);
		start <= 1'b0;
		wait (outstanding == 0);
		repeat (100) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
